// File: rtl/scanline_rle_sprite_decoder_macros.svh
// assertion macros for the scanline rle sprite decoder
`ifndef SCANLINE_RLE_SPRITE_DECODER_MACROS_SVH
`define SCANLINE_RLE_SPRITE_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked on every clock edge out of reset
`define SRLE_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scanline rle decoder: implication failed");
// next-cycle implication
`define SRLE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scanline rle decoder: next-cycle check failed");
`else
`define SRLE_ASSERT_IMPLY(lbl, ante, cons)
`define SRLE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/srle_pkg.sv
// shared types and constants of the scanline rle sprite decoder
package srle_pkg;

    localparam int CFG_AW     = 5;
    localparam int CFG_DW     = 32;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_USER_W = 2;

    // run header fields
    localparam logic [7:0] RUN_REPEAT_BIT = 8'h80;
    localparam logic [7:0] RUN_COUNT_MASK = 8'h7f;

    typedef enum logic [2:0] {
        PH_LEN_HI,
        PH_LEN_LO,
        PH_RUN_HDR,
        PH_RUN_RAW,
        PH_RUN_COLOR,
        PH_LINE_SKIP,
        PH_TAIL,
        PH_DRAIN
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK,
        ST_LINE_SHORT,
        ST_RUN_OVER,
        ST_TRUNC
    } t_status;

    typedef enum logic [2:0] {
        REG_DEST_X,
        REG_DEST_Y,
        REG_IMG_WIDTH,
        REG_IMG_HEIGHT,
        REG_CLIP_LEFT,
        REG_CLIP_TOP,
        REG_CLIP_RIGHT,
        REG_CLIP_BOTTOM
    } t_reg_idx;

endpackage

// File: rtl/scanline_rle_sprite_decoder.sv
// scanline rle sprite decoder: byte stream in, clipped pixel span writes out
//
// Input stream: one encoded byte per beat on s_tdata, s_tlast marks the last
// byte of a block. Output stream: one span write or status beat per result,
// m_tlast marks the beat that ends the block, m_tuser carries its status.
// Registers are written through the APB port; the user must write them only
// while the decoder is idle, which the block does not enforce. The clip
// geometry derived from them is registered in the cycle after a write. An
// accepted byte goes to the input register, then through the single decode
// stage into the output register, at one byte per cycle unless the receiver stalls.
// A byte that gives no result just updates the decoder state.
// When the receiver stalls, the output register holds its beat and the input
// register takes one more byte; after that s_tready drops until the output
// register drains.
// Reset clears the configuration registers to zero, empties both pipeline
// registers and puts the decoder at the start of a block.
`include "scanline_rle_sprite_decoder_macros.svh"

module scanline_rle_sprite_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input byte stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [srle_pkg::IN_DATA_W-1:0]    s_tdata,   // [7:0] data_byte
    input  logic                              s_tlast,   // last_byte
    // output span stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [14:0] span_row, [29:15] span_col, [37:30] span_len,
    // [45:38] span_color, [47:46] zero
    output logic [srle_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic [srle_pkg::OUT_USER_W-1:0]   m_tuser,   // [1:0] status
    output logic                              m_tlast,   // block_done
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [srle_pkg::CFG_AW-1:0]       paddr,
    input  logic [srle_pkg::CFG_DW-1:0]       pwdata,
    output logic [srle_pkg::CFG_DW-1:0]       prdata,
    output logic                              pready
);
    import srle_pkg::*;

    // configuration registers
    logic [15:0] r_dest_x, r_dest_y, r_img_width, r_img_height;
    logic [14:0] r_clip_left, r_clip_top, r_clip_right, r_clip_bottom;

    // registered draw rectangle
    logic        r_g_nonempty;
    logic [14:0] r_g_left, r_g_width, r_g_top, r_g_bottom;
    logic [15:0] r_g_skip;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    // decoder state
    t_phase      r_phase, n_phase;
    logic [15:0] r_line, n_line;
    logic [15:0] r_row, n_row;
    logic [15:0] r_col, n_col;
    logic [15:0] r_skip, n_skip;
    logic [7:0]  r_run, n_run;

    // output register
    logic        r_out_valid;
    logic [14:0] r_out_row, r_out_col;
    logic [7:0]  r_out_len, r_out_color;
    t_status     r_out_status;
    logic        r_out_done;

    // decode results
    logic        w_have_span, w_ended, w_new_block;
    t_status     w_status;
    logic [14:0] w_s_col;
    logic [7:0]  w_s_len, w_s_color;

    logic w_adv, w_fire, w_result, w_cfg_wr;

    // ---------------- register port ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_x      <= '0;
            r_dest_y      <= '0;
            r_img_width   <= '0;
            r_img_height  <= '0;
            r_clip_left   <= '0;
            r_clip_top    <= '0;
            r_clip_right  <= '0;
            r_clip_bottom <= '0;
        end else if (w_cfg_wr) begin
            unique case (t_reg_idx'(paddr[4:2]))
                REG_DEST_X:      r_dest_x      <= pwdata[15:0];
                REG_DEST_Y:      r_dest_y      <= pwdata[15:0];
                REG_IMG_WIDTH:   r_img_width   <= pwdata[15:0];
                REG_IMG_HEIGHT:  r_img_height  <= pwdata[15:0];
                REG_CLIP_LEFT:   r_clip_left   <= pwdata[14:0];
                REG_CLIP_TOP:    r_clip_top    <= pwdata[14:0];
                REG_CLIP_RIGHT:  r_clip_right  <= pwdata[14:0];
                REG_CLIP_BOTTOM: r_clip_bottom <= pwdata[14:0];
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (t_reg_idx'(paddr[4:2]))
            REG_DEST_X:      prdata = {16'h0, r_dest_x};
            REG_DEST_Y:      prdata = {16'h0, r_dest_y};
            REG_IMG_WIDTH:   prdata = {16'h0, r_img_width};
            REG_IMG_HEIGHT:  prdata = {16'h0, r_img_height};
            REG_CLIP_LEFT:   prdata = {17'h0, r_clip_left};
            REG_CLIP_TOP:    prdata = {17'h0, r_clip_top};
            REG_CLIP_RIGHT:  prdata = {17'h0, r_clip_right};
            REG_CLIP_BOTTOM: prdata = {17'h0, r_clip_bottom};
        endcase
    end

    // ---------------- draw rectangle ----------------
    logic signed [17:0] w_left, w_right, w_top, w_bottom;
    logic signed [17:0] w_dx, w_dy, w_xend, w_yend, w_width;
    logic signed [17:0] w_cl, w_ct, w_cr, w_cb;
    logic signed [17:0] w_skip;
    logic               w_nonempty;

    assign w_dx   = {{2{r_dest_x[15]}}, r_dest_x};
    assign w_dy   = {{2{r_dest_y[15]}}, r_dest_y};
    assign w_cl   = {3'b0, r_clip_left};
    assign w_ct   = {3'b0, r_clip_top};
    assign w_cr   = {3'b0, r_clip_right};
    assign w_cb   = {3'b0, r_clip_bottom};
    assign w_xend = w_dx + {2'b0, r_img_width};
    assign w_yend = w_dy + {2'b0, r_img_height};

    assign w_left     = (w_dx > w_cl) ? w_dx : w_cl;
    assign w_right    = (w_xend < w_cr) ? w_xend : w_cr;
    assign w_top      = (w_dy > w_ct) ? w_dy : w_ct;
    assign w_bottom   = (w_yend < w_cb) ? w_yend : w_cb;
    assign w_nonempty = (w_left < w_right) && (w_top < w_bottom);
    assign w_width    = w_right - w_left;
    assign w_skip     = w_left - w_dx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_nonempty <= 1'b0;
        end else begin
            r_g_nonempty <= w_nonempty;
        end
        r_g_left   <= w_left[14:0];
        r_g_width  <= w_nonempty ? w_width[14:0] : 15'd0;
        r_g_top    <= w_top[14:0];
        r_g_bottom <= w_bottom[14:0];
        r_g_skip   <= w_skip[15:0];
    end

    // ---------------- handshake ----------------
    assign w_adv    = !r_out_valid || m_tready;
    assign w_fire   = r_in_valid && w_adv;
    assign s_tready = !r_in_valid || w_adv;
    assign w_result = w_have_span || w_ended;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            r_in_byte <= s_tdata;
            r_in_last <= s_tlast;
        end
    end

    // ---------------- decode helpers ----------------
    logic [15:0]        w_room, w_width16, w_n16, w_line_lo, w_line_dec, w_row_inc;
    logic [7:0]         w_n, w_s, w_d, w_dmin, w_rcnt, w_ccnt;
    logic signed [17:0] w_out_y;
    logic               w_vis;
    t_phase             w_eol_phase, w_eff;

    assign w_width16  = {1'b0, r_g_width};
    assign w_room     = (r_col < w_width16) ? (w_width16 - r_col) : 16'd0;
    assign w_n        = (r_in_byte & RUN_COUNT_MASK) + 8'd1;
    assign w_n16      = {8'h0, w_n};
    // raw run: pixels in the skipped columns plus visible ones up to the room
    assign w_s        = (w_n16 < r_skip) ? w_n : r_skip[7:0];
    assign w_d        = w_n - w_s;
    assign w_dmin     = ({8'h0, w_d} < w_room) ? w_d : w_room[7:0];
    // repeated run: visible count past the skipped columns
    assign w_rcnt     = (w_n16 > r_skip) ? (w_n - r_skip[7:0]) : 8'd0;
    assign w_ccnt     = ({8'h0, r_run} < w_room) ? r_run : w_room[7:0];
    assign w_line_lo  = {r_line[15:8], r_in_byte};
    assign w_line_dec = (r_line != 16'd0) ? (r_line - 16'd1) : 16'd0;
    assign w_row_inc  = (r_row != 16'hffff) ? (r_row + 16'd1) : r_row;
    assign w_eol_phase = (w_row_inc >= r_img_height) ? PH_TAIL : PH_LEN_HI;
    assign w_out_y    = w_dy + {2'b0, r_row};
    assign w_vis      = r_g_nonempty && (w_out_y >= $signed({3'b0, r_g_top}))
                        && (w_out_y < $signed({3'b0, r_g_bottom}));
    assign w_eff      = (r_phase == PH_LEN_HI
                         && (!r_g_nonempty || r_row >= r_img_height)) ? PH_TAIL : r_phase;

    // ---------------- next state and result ----------------
    always_comb begin
        n_phase     = w_eff;
        n_line      = r_line;
        n_row       = r_row;
        n_col       = r_col;
        n_skip      = r_skip;
        n_run       = r_run;
        w_have_span = 1'b0;
        w_ended     = 1'b0;
        w_status    = ST_OK;
        w_s_col     = '0;
        w_s_len     = '0;
        w_s_color   = '0;
        w_new_block = 1'b0;

        unique case (w_eff)
            PH_LEN_HI: begin
                n_line = {r_in_byte, 8'h00};
                if (r_in_last) begin
                    w_status = ST_TRUNC;
                    w_ended  = 1'b1;
                end else begin
                    n_phase = PH_LEN_LO;
                end
            end
            PH_LEN_LO: begin
                n_line = w_line_lo;
                if (r_in_last && w_line_lo != 16'd0) begin
                    w_status = ST_TRUNC;
                    w_ended  = 1'b1;
                end else begin
                    if (w_vis) begin
                        n_col  = '0;
                        n_skip = r_g_skip;
                        n_run  = '0;
                        if (w_line_lo == 16'd0) begin
                            w_status = ST_LINE_SHORT;
                            w_ended  = 1'b1;
                        end else begin
                            n_phase = PH_RUN_HDR;
                        end
                    end else if (w_line_lo == 16'd0) begin
                        n_row   = w_row_inc;
                        n_phase = w_eol_phase;
                    end else begin
                        n_phase = PH_LINE_SKIP;
                    end
                    if (r_in_last && !w_ended) begin
                        w_ended = 1'b1;
                        if (n_phase != PH_TAIL) w_status = ST_TRUNC;
                    end
                end
            end
            PH_RUN_HDR, PH_RUN_RAW, PH_RUN_COLOR, PH_LINE_SKIP: begin
                n_line = w_line_dec;
                // per-phase byte handling
                if (w_eff == PH_RUN_HDR) begin
                    if (w_room == 16'd0) begin
                        n_phase = PH_LINE_SKIP;
                    end else if ((r_in_byte & RUN_REPEAT_BIT) == 8'h00) begin
                        n_run   = w_s + w_dmin;
                        n_phase = PH_RUN_RAW;
                    end else begin
                        if (w_n16 <= r_skip) begin
                            n_skip = r_skip - w_n16;
                            n_run  = '0;
                        end else begin
                            n_skip = '0;
                            n_run  = ({8'h0, w_rcnt} < w_room) ? w_rcnt : w_room[7:0];
                        end
                        n_phase = PH_RUN_COLOR;
                    end
                end else if (w_eff == PH_RUN_RAW || w_eff == PH_RUN_COLOR) begin
                    if (w_eff == PH_RUN_RAW) begin
                        if (r_skip != 16'd0) begin
                            n_skip = r_skip - 16'd1;
                        end else if (w_room != 16'd0) begin
                            w_have_span = 1'b1;
                            w_s_col     = r_g_left + r_col[14:0];
                            w_s_len     = 8'd1;
                            w_s_color   = r_in_byte;
                            n_col       = r_col + 16'd1;
                        end
                        if (r_run != 8'd0) n_run = r_run - 8'd1;
                    end else begin
                        if (w_ccnt != 8'd0 && r_in_byte != 8'd0) begin
                            w_have_span = 1'b1;
                            w_s_col     = r_g_left + r_col[14:0];
                            w_s_len     = w_ccnt;
                            w_s_color   = r_in_byte;
                        end
                        n_col = r_col + {8'h0, w_ccnt};
                        n_run = '0;
                    end
                    if (n_run == 8'd0) begin
                        n_phase = (n_col >= w_width16) ? PH_LINE_SKIP : PH_RUN_HDR;
                    end
                end
                // line end and stream end
                if (r_in_last && w_line_dec != 16'd0) begin
                    w_have_span = 1'b0;
                    w_status    = ST_TRUNC;
                    w_ended     = 1'b1;
                end else begin
                    if (w_line_dec == 16'd0) begin
                        priority case (n_phase)
                            PH_LINE_SKIP: begin
                                n_row   = w_row_inc;
                                n_phase = w_eol_phase;
                            end
                            PH_RUN_HDR: begin
                                w_status = ST_LINE_SHORT;
                                w_ended  = 1'b1;
                            end
                            PH_RUN_RAW: begin
                                w_status = ({8'h0, n_run} <= n_skip) ? ST_LINE_SHORT
                                                                     : ST_RUN_OVER;
                                w_ended  = 1'b1;
                            end
                            default: begin
                                w_status = (n_run == 8'd0) ? ST_LINE_SHORT : ST_RUN_OVER;
                                w_ended  = 1'b1;
                            end
                        endcase
                    end
                    if (r_in_last && !w_ended) begin
                        w_ended = 1'b1;
                        if (n_phase != PH_TAIL) w_status = ST_TRUNC;
                    end
                end
            end
            PH_TAIL: begin
                if (r_in_last) w_ended = 1'b1;
            end
            PH_DRAIN: begin
                if (r_in_last) w_new_block = 1'b1;
            end
        endcase

        // block end: restart on the last byte, otherwise drop up to it
        if (w_ended) begin
            if (r_in_last) w_new_block = 1'b1;
            else n_phase = PH_DRAIN;
        end
        if (w_new_block) begin
            n_phase = PH_LEN_HI;
            n_line  = '0;
            n_row   = '0;
            n_col   = '0;
            n_skip  = '0;
            n_run   = '0;
        end
    end

    // decoder state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEN_HI;
            r_line  <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_skip  <= '0;
            r_run   <= '0;
        end else if (w_fire) begin
            r_phase <= n_phase;
            r_line  <= n_line;
            r_row   <= n_row;
            r_col   <= n_col;
            r_skip  <= n_skip;
            r_run   <= n_run;
        end
    end

    // ---------------- output register ----------------
    // span fields read as zero on a status-only beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_fire && w_result;
        end
        if (w_fire && w_result) begin
            r_out_row    <= w_have_span ? w_out_y[14:0] : 15'd0;
            r_out_col    <= w_have_span ? w_s_col : 15'd0;
            r_out_len    <= w_have_span ? w_s_len : 8'd0;
            r_out_color  <= w_have_span ? w_s_color : 8'd0;
            r_out_status <= w_status;
            r_out_done   <= w_ended;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {2'b00, r_out_color, r_out_len, r_out_col, r_out_row};
    assign m_tuser  = r_out_status;
    assign m_tlast  = r_out_done;

    // ---------------- assertions ----------------
    `SRLE_ASSERT_IMPLY(a_no_empty_beat, r_out_valid && !r_out_done, r_out_len != 8'd0)
    `SRLE_ASSERT_IMPLY(a_error_ends_block, r_out_valid && r_out_status != ST_OK, r_out_done)
    `SRLE_ASSERT_NEXT(a_drain_after_end, w_fire && w_ended && !r_in_last, r_phase == PH_DRAIN)

endmodule
